/* hw/rtl/cvtp_pkg.sv */
// ----------------------------------------------------------------------------
// cvtp_pkg: shared types and constants of the camera view transform core
// Register indexes, reset values, datapath widths and the divider interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cvtp_pkg;

  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 600;

  // Field widths.
  localparam int COORD_W = 24;
  localparam int TRIG_W  = 16;
  localparam int FOCAL_W = 12;
  localparam int SCR_W   = 16;
  localparam int CFG_IDX_W = 4;

  // Fractional bits of the trig words.
  localparam int TRIG_FRAC = 14;

  // Screen centre, signed, wide enough for any screen size up to 4096.
  localparam int CENTRE_W = 13;

  // Projection divider: numerator magnitude, divisor and quotient widths.
  localparam int MAG_W   = 43;
  localparam int DEN_W   = 30;
  localparam int QUO_W   = 16;
  localparam int CMP_W   = DEN_W + QUO_W;
  localparam int DIV_LAT = QUO_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X     = 4'd0,
    REG_CAMERA_Y     = 4'd1,
    REG_CAMERA_Z     = 4'd2,
    REG_COS_YAW      = 4'd3,
    REG_SIN_YAW      = 4'd4,
    REG_COS_ELEV     = 4'd5,
    REG_SIN_ELEV     = 4'd6,
    REG_FOCAL_LENGTH = 4'd7
  } cvtp_reg_t;

  localparam logic signed [COORD_W-1:0] CAMERA_X_RST  = '0;
  localparam logic signed [COORD_W-1:0] CAMERA_Y_RST  = '0;
  localparam logic signed [COORD_W-1:0] CAMERA_Z_RST  = -24'sd76800;
  localparam logic signed [TRIG_W-1:0]  COS_RST       = 16'sd16384;
  localparam logic signed [TRIG_W-1:0]  SIN_RST       = '0;
  localparam logic        [FOCAL_W-1:0] FOCAL_RST     = 12'd500;
  localparam logic signed [SCR_W-1:0]   SCR_HIDDEN    = -16'sd1;
  localparam logic signed [COORD_W-1:0] DEPTH_MAX     = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] DEPTH_MIN     = 24'sh800000;

  // Divider input and output.
  typedef struct packed {
    logic [MAG_W+1:0]   num;   // signed numerator
    logic [DEN_W-1:0]   den;
  } cvtp_div_in_t;

  typedef struct packed {
    logic             neg;
    logic [QUO_W-1:0] quo;   // top bit set means the magnitude overflowed
  } cvtp_div_out_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic                      vis;
    logic signed [COORD_W-1:0] depth;
  } cvtp_side_t;

endpackage

/* hw/rtl/cvtp_div.sv */
// ----------------------------------------------------------------------------
// cvtp_div: pipelined sign-magnitude divider for the projection
// Takes the absolute value of the numerator, then resolves one quotient bit
// per stage from the overflow bit down, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvtp_div (
  input  logic                   clk,
  input  logic                   en,
  input  cvtp_pkg::cvtp_div_in_t div_in,
  output cvtp_pkg::cvtp_div_out_t div_out
);
  import cvtp_pkg::*;

  localparam int NUM_W = MAG_W + 2;

  logic signed [NUM_W-1:0] num;
  logic        [NUM_W-1:0] num_abs;

  logic [MAG_W-1:0] rem_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic [DEN_W-1:0] den_r [0:QUO_W];
  logic             neg_r [0:QUO_W];

  assign num     = $signed(div_in.num);
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_abs[MAG_W-1:0];
      quo_r[0] <= '0;
      den_r[0] <= div_in.den;
      neg_r[0] <= num[NUM_W-1];
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int K = QUO_W - 1 - i;
    logic [CMP_W:0]   diff;
    logic             ge;
    logic [MAG_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    always_comb begin
      diff    = {1'b0, CMP_W'(rem_r[i])} - {1'b0, (CMP_W'(den_r[i]) << K)};
      ge      = !diff[CMP_W];
      rem_nxt = ge ? diff[MAG_W-1:0] : rem_r[i];
      quo_nxt = quo_r[i];
      quo_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= rem_nxt;
        quo_r[i+1] <= quo_nxt;
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign div_out.neg = neg_r[QUO_W];
  assign div_out.quo = quo_r[QUO_W];

endmodule

/* hw/rtl/camera_view_transform_projection_core.sv */
// ----------------------------------------------------------------------------
// camera_view_transform_projection_core: view transform and projection
// From input transaction to result, a point passes through seven arithmetic
// stages, a 17-stage divider and the output register.
// Throughput is one point per cycle; the whole pipeline advances together
// and holds while a finished result waits to be taken.
// Reset clears the pipeline valid bits and loads the camera registers with
// their default view; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_view_transform_projection_core #(
  parameter int SCREEN_WIDTH  = cvtp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = cvtp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // point_x [23:0], point_y [47:24], point_z [71:48]
  input  logic [71:0]                    in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pixel column [15:0], pixel row [31:16], view_depth [55:32]
  output logic [55:0]                    out_tdata,
  // visible [0]
  output logic                           out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cvtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cvtp_pkg::COORD_W-1:0]   cfg_data
);
  import cvtp_pkg::*;

  localparam logic signed [CENTRE_W-1:0] CENTRE_X = CENTRE_W'(SCREEN_WIDTH / 2);
  localparam logic signed [CENTRE_W-1:0] CENTRE_Y = CENTRE_W'(SCREEN_HEIGHT / 2);
  localparam int PIPE_N = 7 + DIV_LAT;

  // Configuration registers.
  logic signed [COORD_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [TRIG_W-1:0]  cos_yaw_r, sin_yaw_r, cos_elev_r, sin_elev_r;
  logic        [FOCAL_W-1:0] focal_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r     <= CAMERA_X_RST;
      cam_y_r     <= CAMERA_Y_RST;
      cam_z_r     <= CAMERA_Z_RST;
      cos_yaw_r   <= COS_RST;
      sin_yaw_r   <= SIN_RST;
      cos_elev_r  <= COS_RST;
      sin_elev_r  <= SIN_RST;
      focal_r     <= FOCAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAMERA_X:     cam_x_r     <= cfg_data;
        REG_CAMERA_Y:     cam_y_r     <= cfg_data;
        REG_CAMERA_Z:     cam_z_r     <= cfg_data;
        REG_COS_YAW:      cos_yaw_r   <= cfg_data[TRIG_W-1:0];
        REG_SIN_YAW:      sin_yaw_r   <= cfg_data[TRIG_W-1:0];
        REG_COS_ELEV:     cos_elev_r  <= cfg_data[TRIG_W-1:0];
        REG_SIN_ELEV:     sin_elev_r  <= cfg_data[TRIG_W-1:0];
        REG_FOCAL_LENGTH: focal_r     <= cfg_data[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves when the output register can take data.
  logic              adv;
  logic [PIPE_N-1:0] vld_r;
  logic              out_vld_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[PIPE_N-2:0], in_tvalid};
      out_vld_r <= vld_r[PIPE_N-1];
    end
  end

  // Stage 1: offset from the camera.
  logic signed [COORD_W:0] dx_r, dy1_r, dz_r;
  // Stage 2: yaw products.
  logic signed [40:0]      pxc_r, pzs_r, pxs_r, pzc_r;
  logic signed [COORD_W:0] dy2_r;
  // Stage 3: yaw rotation.
  logic signed [27:0]      xr3_r, zr_r;
  logic signed [COORD_W:0] dy3_r;
  // Stage 4: pitch products.
  logic signed [40:0]      pyc_r, pys_r;
  logic signed [43:0]      pzs2_r, pzc2_r;
  logic signed [27:0]      xr4_r;
  // Stage 5: pitch rotation.
  logic signed [30:0]      yr_r, zf_r;
  logic signed [27:0]      xr5_r;
  // Stage 6: projection products.
  logic signed [43:0]      cxz_r, cyz_r, yf_r;
  logic signed [40:0]      xf_r;
  logic [DEN_W-1:0]        den6_r;
  cvtp_side_t              side6_r;
  // Stage 7: numerators.
  logic signed [MAG_W+1:0] nx_r, ny_r;
  logic [DEN_W-1:0]        den7_r;
  cvtp_side_t              side7_r;

  logic signed [41:0]       yaw_x, yaw_z;
  logic signed [44:0]       pitch_y, pitch_z;
  logic signed [FOCAL_W:0]  focal_s;
  cvtp_side_t               side_nxt;

  assign yaw_x   = pxc_r - pzs_r;
  assign yaw_z   = pxs_r + pzc_r;
  assign pitch_y = pyc_r - pzs2_r;
  assign pitch_z = pys_r + pzc2_r;
  assign focal_s = $signed({1'b0, focal_r});

  always_comb begin
    side_nxt.vis = (zf_r > 0);
    if (zf_r > 31'(DEPTH_MAX)) begin
      side_nxt.depth = DEPTH_MAX;
    end else if (zf_r < 31'(DEPTH_MIN)) begin
      side_nxt.depth = DEPTH_MIN;
    end else begin
      side_nxt.depth = zf_r[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r    <= $signed(in_tdata[23:0])  - cam_x_r;
      dy1_r   <= $signed(in_tdata[47:24]) - cam_y_r;
      dz_r    <= $signed(in_tdata[71:48]) - cam_z_r;

      pxc_r   <= dx_r * cos_yaw_r;
      pzs_r   <= dz_r * sin_yaw_r;
      pxs_r   <= dx_r * sin_yaw_r;
      pzc_r   <= dz_r * cos_yaw_r;
      dy2_r   <= dy1_r;

      xr3_r   <= 28'(yaw_x >>> TRIG_FRAC);
      zr_r    <= 28'(yaw_z >>> TRIG_FRAC);
      dy3_r   <= dy2_r;

      pyc_r   <= dy3_r * cos_elev_r;
      pys_r   <= dy3_r * sin_elev_r;
      pzs2_r  <= zr_r * sin_elev_r;
      pzc2_r  <= zr_r * cos_elev_r;
      xr4_r   <= xr3_r;

      yr_r    <= 31'(pitch_y >>> TRIG_FRAC);
      zf_r    <= 31'(pitch_z >>> TRIG_FRAC);
      xr5_r   <= xr4_r;

      cxz_r   <= CENTRE_X * zf_r;
      cyz_r   <= CENTRE_Y * zf_r;
      xf_r    <= xr5_r * focal_s;
      yf_r    <= yr_r * focal_s;
      den6_r  <= zf_r[DEN_W-1:0];
      side6_r <= side_nxt;

      nx_r    <= cxz_r + xf_r;
      ny_r    <= cyz_r - yf_r;
      den7_r  <= den6_r;
      side7_r <= side6_r;
    end
  end

  // Dividers for both screen axes.
  cvtp_div_in_t  divx_in, divy_in;
  cvtp_div_out_t divx_out, divy_out;

  assign divx_in.num = nx_r;
  assign divx_in.den = den7_r;
  assign divy_in.num = ny_r;
  assign divy_in.den = den7_r;

  cvtp_div u_div_x (
    .clk     (clk),
    .en      (adv),
    .div_in  (divx_in),
    .div_out (divx_out)
  );

  cvtp_div u_div_y (
    .clk     (clk),
    .en      (adv),
    .div_in  (divy_in),
    .div_out (divy_out)
  );

  // Visibility and depth follow the dividers through a matching delay line.
  cvtp_side_t side_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side7_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  function automatic logic signed [SCR_W-1:0] scr_sat(input cvtp_div_out_t d);
    logic signed [SCR_W-1:0] mag;
    mag = $signed({1'b0, d.quo[QUO_W-2:0]});
    if (d.quo[QUO_W-1]) begin
      return d.neg ? 16'sh8000 : 16'sh7FFF;
    end
    return d.neg ? -mag : mag;
  endfunction

  cvtp_side_t              side_out;
  logic signed [SCR_W-1:0] scr_x_nxt, scr_y_nxt;
  logic signed [SCR_W-1:0] scr_x_r, scr_y_r;
  logic signed [COORD_W-1:0] depth_r;
  logic                    vis_r;

  assign side_out  = side_r[DIV_LAT-1];
  assign scr_x_nxt = side_out.vis ? scr_sat(divx_out) : SCR_HIDDEN;
  assign scr_y_nxt = side_out.vis ? scr_sat(divy_out) : SCR_HIDDEN;

  always_ff @(posedge clk) begin
    if (adv) begin
      scr_x_r <= scr_x_nxt;
      scr_y_r <= scr_y_nxt;
      depth_r <= side_out.depth;
      vis_r   <= side_out.vis;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = vis_r;
  assign out_tdata  = {depth_r, scr_y_r, scr_x_r};

  // A hidden point always reports both coordinates as minus one.
  a_hidden_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (scr_x_r == SCR_HIDDEN && scr_y_r == SCR_HIDDEN))
    else $error("hidden point with projected coordinates");

  // A visible point has a strictly positive saturated depth.
  a_visible_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (!depth_r[COORD_W-1] && depth_r != '0))
    else $error("visible point with non-positive depth");

  // While the output stalls, no transaction is dropped or duplicated inside.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (vld_r == $past(vld_r) && out_vld_r))
    else $error("pipeline moved during a stall");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for camera_view_transform_projection_core
// World points stream in through a bursty driver. A predictor mirrors the
// camera registers and computes each expected projection. A monitor behind
// a stalling receiver compares every result field by field. The camera is
// reprogrammed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cvtp_pkg::*;

  localparam int     PIPE_LATENCY     = 25;
  localparam int     CYCLE_LIMIT      = 200000;
  localparam int     RANDOM_PER_PHASE = 95;
  localparam int     NUM_PHASES       = 8;
  localparam int     NUM_REGS         = 8;
  localparam int     HOLD_AT          = 150;
  localparam int     HOLD_CYCLES      = 300;
  localparam longint CENTRE_X         = SCREEN_WIDTH_DEF / 2;
  localparam longint CENTRE_Y         = SCREEN_HEIGHT_DEF / 2;
  localparam longint SCR_MIN          = -32768;
  localparam longint SCR_MAX          = 32767;
  localparam int     COORD_MIN        = -8388608;
  localparam int     COORD_MAX        = 8388607;

  // Fields from the lowest bit up: x, y, z.
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct {
    logic signed [SCR_W-1:0]   col;
    logic signed [SCR_W-1:0]   row;
    logic                      vis;
    logic signed [COORD_W-1:0] depth;
  } projection_t;

  typedef struct {
    logic signed [COORD_W-1:0] cam_x;
    logic signed [COORD_W-1:0] cam_y;
    logic signed [COORD_W-1:0] cam_z;
    logic signed [TRIG_W-1:0]  cos_yaw;
    logic signed [TRIG_W-1:0]  sin_yaw;
    logic signed [TRIG_W-1:0]  cos_elev;
    logic signed [TRIG_W-1:0]  sin_elev;
    logic [FOCAL_W-1:0]        focal;
  } view_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic [71:0]          in_tdata   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [55:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [COORD_W-1:0]   cfg_data   = '0;

  view_t       view;
  point_t      pending_points[$];
  projection_t expected_q[$];

  int errors        = 0;
  int points_in     = 0;
  int results_seen  = 0;
  int visible_seen  = 0;
  int clipped_seen  = 0;
  int cycle_count   = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int stall_tick    = 0;

  camera_view_transform_projection_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Yaw about y, then pitch about x, each product sum floored back to Q.8;
  // perspective divide truncates towards zero as a whole.
  function automatic projection_t predict_view(point_t p, view_t v);
    longint      dx, dy, dz, xr, zr, yr, zf, f;
    projection_t r;
    dx = p.x - v.cam_x;
    dy = p.y - v.cam_y;
    dz = p.z - v.cam_z;
    f  = v.focal;
    xr = (dx * v.cos_yaw - dz * v.sin_yaw) >>> TRIG_FRAC;
    zr = (dx * v.sin_yaw + dz * v.cos_yaw) >>> TRIG_FRAC;
    yr = (dy * v.cos_elev - zr * v.sin_elev) >>> TRIG_FRAC;
    zf = (dy * v.sin_elev + zr * v.cos_elev) >>> TRIG_FRAC;
    r.depth = COORD_W'(clamp(zf, DEPTH_MIN, DEPTH_MAX));
    r.vis   = (zf > 0);
    if (r.vis) begin
      r.col = SCR_W'(clamp((CENTRE_X * zf + xr * f) / zf, SCR_MIN, SCR_MAX));
      r.row = SCR_W'(clamp((CENTRE_Y * zf - yr * f) / zf, SCR_MIN, SCR_MAX));
    end else begin
      r.col = SCR_HIDDEN;
      r.row = SCR_HIDDEN;
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] near_offset();
    int m;
    int o;
    m = $urandom_range(4, 20);
    o = $urandom_range(0, 1 << m);
    return COORD_W'(($urandom_range(0, 1) != 0) ? o : -o);
  endfunction

  // Mostly points scattered around the camera, some anywhere in the field range.
  function automatic point_t random_point(view_t v);
    point_t p;
    if ($urandom_range(0, 3) == 0) begin
      p.x = COORD_W'($urandom);
      p.y = COORD_W'($urandom);
      p.z = COORD_W'($urandom);
    end else begin
      p.x = v.cam_x + near_offset();
      p.y = v.cam_y + near_offset();
      p.z = v.cam_z + near_offset();
    end
    return p;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic push_point(int x, int y, int z);
    point_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    pending_points.push_back(p);
  endtask

  task automatic queue_phase_points();
    for (int k = 0; k < 8; k++) begin
      push_point(k[0] ? COORD_MAX : COORD_MIN, k[1] ? COORD_MAX : COORD_MIN,
                 k[2] ? COORD_MAX : COORD_MIN);
    end
    for (int k = 0; k < RANDOM_PER_PHASE; k++) pending_points.push_back(random_point(view));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CAMERA_X:     view.cam_x     = data;
      REG_CAMERA_Y:     view.cam_y     = data;
      REG_CAMERA_Z:     view.cam_z     = data;
      REG_COS_YAW:      view.cos_yaw   = data[TRIG_W-1:0];
      REG_SIN_YAW:      view.sin_yaw   = data[TRIG_W-1:0];
      REG_COS_ELEV:     view.cos_elev  = data[TRIG_W-1:0];
      REG_SIN_ELEV:     view.sin_elev  = data[TRIG_W-1:0];
      REG_FOCAL_LENGTH: view.focal     = data[FOCAL_W-1:0];
      default: ;
    endcase
  endtask

  // Narrow registers get random junk above their width, which must be dropped.
  task automatic set_view(int cx, int cy, int cz, int c_yaw, int s_yaw, int c_pitch,
                          int s_pitch, int focal);
    logic [7:0]  pad8;
    logic [11:0] pad12;
    pad8  = 8'($urandom);
    pad12 = 12'($urandom);
    write_reg(REG_CAMERA_X, COORD_W'(cx));
    write_reg(REG_CAMERA_Y, COORD_W'(cy));
    write_reg(REG_CAMERA_Z, COORD_W'(cz));
    write_reg(REG_COS_YAW, {pad8, c_yaw[15:0]});
    write_reg(REG_SIN_YAW, {~pad8, s_yaw[15:0]});
    write_reg(REG_COS_ELEV, {pad8, c_pitch[15:0]});
    write_reg(REG_SIN_ELEV, {~pad8, s_pitch[15:0]});
    write_reg(REG_FOCAL_LENGTH, {pad12, focal[11:0]});
  endtask

  task automatic set_random_angles(bit raw_words);
    real yaw, pitch;
    int  cam_span;
    yaw      = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    pitch    = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    cam_span = 1 << $urandom_range(8, 22);
    if (raw_words)
      set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
    else
      set_view($urandom_range(0, 2 * cam_span) - cam_span,
               $urandom_range(0, 2 * cam_span) - cam_span,
               $urandom_range(0, 2 * cam_span) - cam_span,
               int'(16384.0 * $cos(yaw)), int'(16384.0 * $sin(yaw)),
               int'(16384.0 * $cos(pitch)), int'(16384.0 * $sin(pitch)),
               $urandom_range(1, 4095));
  endtask

  task automatic wait_until_drained();
    while (pending_points.size() != 0 || in_tvalid || expected_q.size() != 0)
      @(posedge clk);
  endtask

  // Driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : point_driver
    point_t p;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        p = point_t'(in_tdata);
        expected_q.push_back(predict_view(p, view));
        points_in <= points_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          in_tdata  <= pending_points.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            if ($urandom_range(0, 2) == 0)
              gap_left <= 0;
            else if ($urandom_range(0, 7) == 0)
              gap_left <= $urandom_range(10, 40);
            else
              gap_left <= $urandom_range(1, 4);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern that steps through modes chosen by stall_tick[9:8],
  // plus one long hold-off that lets the pipeline fill and push back on the input.
  always @(posedge clk) begin : result_receiver
    stall_tick <= stall_tick + 1;
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && points_in >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      case (stall_tick[9:8])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 3) != 0);
        2'd2: out_tready <= ((stall_tick % 7) > 1);
        default: out_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_monitor
    projection_t             want;
    logic signed [SCR_W-1:0] got_col, got_row;
    if (rst_n && out_tvalid && out_tready) begin
      got_col = out_tdata[15:0];
      got_row = out_tdata[31:16];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no point outstanding, tdata %h", $time, out_tdata);
      end else begin
        want = expected_q.pop_front();
        results_seen++;
        if (want.vis) visible_seen++;
        if (want.vis && (want.col == SCR_MIN || want.col == SCR_MAX ||
                         want.row == SCR_MIN || want.row == SCR_MAX))
          clipped_seen++;
        check_field("column", want.col, got_col);
        check_field("row", want.row, got_row);
        check_field("visible", want.vis, out_tuser);
        check_field("view_depth", want.depth, $signed(out_tdata[55:32]));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout with %0d results still outstanding", expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    view.cam_x     = CAMERA_X_RST;
    view.cam_y     = CAMERA_Y_RST;
    view.cam_z     = CAMERA_Z_RST;
    view.cos_yaw   = COS_RST;
    view.sin_yaw   = SIN_RST;
    view.cos_elev  = COS_RST;
    view.sin_elev  = SIN_RST;
    view.focal     = FOCAL_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset view: camera at z = -300 looking down +z.
    push_point(0, 0, 0);
    push_point(25600, 12800, 0);
    push_point(-25600, -12800, 25600);
    push_point(0, 0, -76800);                   // depth exactly zero
    push_point(0, 0, -102400);                  // behind the camera
    push_point(0, 0, -76799);                   // smallest positive depth
    push_point(COORD_MAX, COORD_MIN, -76544);   // projects far off screen
    push_point(COORD_MIN, COORD_MAX, -76799);
    push_point(0, 0, COORD_MAX);                // depth beyond 24 bits
    push_point(0, 0, COORD_MIN);
    push_point(5592405, -5592406, 5592405);
    push_point(-5592406, 5592405, -5592406);
    push_point(256, 256, -76544);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: ;
        1: set_view(2560, -1280, -51200, 14189, 8192, 15396, -5604, 500);
        2: set_view(COORD_MAX, COORD_MAX, COORD_MAX, 16384, -16384, -16384, 16384, 4095);
        3: begin
          // Trig words beyond unity and a zero focal length.
          set_view(COORD_MIN, COORD_MIN, COORD_MIN, -32768, 32767, 32767, -32768, 0);
          write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                    COORD_W'($urandom));
        end
        6: begin
          set_random_angles(1'b1);
          write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                    COORD_W'($urandom));
        end
        7: begin
          set_random_angles(1'b0);
          write_reg(REG_FOCAL_LENGTH, COORD_W'(1));
        end
        default: set_random_angles(1'b0);
      endcase
      queue_phase_points();
      wait_until_drained();
    end

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    $display("Projected %0d points under %0d camera set-ups: %0d visible, %0d hidden.",
             results_seen, NUM_PHASES, visible_seen, results_seen - visible_seen);
    $display("%0d visible points hit screen saturation; one %0d-cycle output hold-off.",
             clipped_seen, HOLD_CYCLES);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cvtp_pkg.sv
hw/rtl/cvtp_div.sv
hw/rtl/camera_view_transform_projection_core.sv
bench/testbench.sv
